// ===== src/awmd_pkg.sv =====
// ----------------------------------------------------------------------------
// awmd_pkg
// Shared types and constants for the alpha-weighted 2x2 mip downsampler.
// ----------------------------------------------------------------------------
package awmd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned QUAD_N    = 4;
  localparam int unsigned COLOR_N   = 3;
  localparam int unsigned MASK_N    = 4;
  localparam int unsigned LANE_N    = COLOR_N + MASK_N;
  localparam int unsigned ASUM_W    = 10;   // sum of four bytes
  localparam int unsigned NUM_W     = 18;   // weighted sum plus rounding
  localparam int unsigned QUO_W     = 8;
  localparam int unsigned DEN_W     = ASUM_W + QUO_W - 1;  // divisor pre-shifted
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGE_N     = QUO_W / STEPS_PER_STAGE;
  localparam int unsigned CFG_W     = 3;
  localparam logic [CFG_W-1:0] MASK_CH_RESET = 3'd4;
  localparam int unsigned PADDR_W   = 3;
  localparam logic REG_MASK_CH = 1'b0;   // register index at paddr[2]

  typedef struct packed {
    logic [QUAD_N-1:0][WORD_W-1:0] texel;
    logic [QUAD_N-1:0][WORD_W-1:0] mask;
  } awmd_quad_t;

  typedef struct packed {
    logic [LANE_N-1:0][NUM_W-1:0] rem;
    logic [DEN_W-1:0]             den;
    logic [LANE_N-1:0][QUO_W-1:0] quo;
    logic [BYTE_W-1:0]            alpha;
    logic [MASK_N-1:0]            mask_en;
  } awmd_work_t;

endpackage

// ===== src/awmd_if.sv =====
// ----------------------------------------------------------------------------
// awmd_if
// Valid/ready channels for texel quads and downsampled texels.
// ----------------------------------------------------------------------------
interface awmd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_top_left;
  logic [31:0] texel_top_right;
  logic [31:0] texel_bottom_left;
  logic [31:0] texel_bottom_right;
  logic [31:0] mask_top_left;
  logic [31:0] mask_top_right;
  logic [31:0] mask_bottom_left;
  logic [31:0] mask_bottom_right;

  modport source (
    output valid, texel_top_left, texel_top_right, texel_bottom_left,
           texel_bottom_right, mask_top_left, mask_top_right,
           mask_bottom_left, mask_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, texel_top_left, texel_top_right, texel_bottom_left,
           texel_bottom_right, mask_top_left, mask_top_right,
           mask_bottom_left, mask_bottom_right,
    output ready
  );
endinterface

interface awmd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_texel;
  logic [31:0] out_mask;

  modport source (output valid, out_texel, out_mask, input ready);
  modport sink (input valid, out_texel, out_mask, output ready);
endinterface

// ===== src/awmd_front.sv =====
// ----------------------------------------------------------------------------
// awmd_front
// First stage: alpha sum, weighted and plain channel sums, divider setup.
// ----------------------------------------------------------------------------
module awmd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  awmd_pkg::awmd_quad_t           quad_i,
  input  logic [awmd_pkg::CFG_W-1:0]     mask_channels_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output awmd_pkg::awmd_work_t           work_o
);
  import awmd_pkg::*;

  logic       valid_q;
  awmd_work_t work_d, work_q;

  always_comb begin
    logic [ASUM_W-1:0] asum;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] v;
    logic [NUM_W-1:0]  wsum;
    logic [ASUM_W-1:0] psum;
    asum = '0;
    for (int q = 0; q < QUAD_N; q++) begin
      asum = asum + ASUM_W'(quad_i.texel[q][WORD_W-1 -: BYTE_W]);
    end
    work_d = '0;
    for (int l = 0; l < LANE_N; l++) begin
      wsum = '0;
      psum = '0;
      for (int q = 0; q < QUAD_N; q++) begin
        a = quad_i.texel[q][WORD_W-1 -: BYTE_W];
        if (l < COLOR_N) begin
          v = quad_i.texel[q][BYTE_W*l +: BYTE_W];
        end else begin
          v = quad_i.mask[q][BYTE_W*(l-COLOR_N) +: BYTE_W];
        end
        wsum = wsum + NUM_W'(v * a);
        psum = psum + ASUM_W'(v);
      end
      if (asum != '0) begin
        work_d.rem[l] = (l < COLOR_N) ? wsum + NUM_W'(asum >> 1) : wsum;
      end else begin
        work_d.rem[l] = (l < COLOR_N) ? NUM_W'(psum) + NUM_W'(2) : NUM_W'(psum);
      end
    end
    work_d.den   = (asum != '0) ? DEN_W'(asum) << (QUO_W - 1)
                                : DEN_W'(QUAD_N) << (QUO_W - 1);
    work_d.alpha = BYTE_W'((asum + ASUM_W'(2)) >> 2);
    for (int c = 0; c < MASK_N; c++) begin
      work_d.mask_en[c] = CFG_W'(c) < mask_channels_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== src/awmd_div_stage.sv =====
// ----------------------------------------------------------------------------
// awmd_div_stage
// Divider stage: two restoring quotient bits for every lane.
// ----------------------------------------------------------------------------
module awmd_div_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  awmd_pkg::awmd_work_t work_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output awmd_pkg::awmd_work_t work_o
);
  import awmd_pkg::*;

  logic       valid_q;
  awmd_work_t work_d, work_q;

  always_comb begin
    logic take;
    work_d = work_i;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int l = 0; l < LANE_N; l++) begin
        take = work_d.rem[l] >= NUM_W'(work_d.den);
        if (take) begin
          work_d.rem[l] = work_d.rem[l] - NUM_W'(work_d.den);
        end
        work_d.quo[l] = {work_d.quo[l][QUO_W-2:0], take};
      end
      work_d.den = work_d.den >> 1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== src/alpha_weighted_mip_downsample.sv =====
// ----------------------------------------------------------------------------
// alpha_weighted_mip_downsample
// Alpha-weighted 2x2 box mip downsample, five register stages.
//
//   port     dir   protocol    word
//   in_if    in    valid/ready texel quad: four texels, four mask words
//   out_if   out   valid/ready out_texel, out_mask
//   apb      in    APB write   mask_channels at 0x0
//
// One word per cycle sustained while out_if.ready holds; a sum stage and four
// divider stages, two quotient bits each. The last stage is the output
// register. Ready propagates back stage by stage, so a stall holds every
// full stage and fills bubbles. Reset clears all valid bits and sets
// mask_channels to four.
// ----------------------------------------------------------------------------
module alpha_weighted_mip_downsample (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  awmd_in_if.sink                          in_if,
  awmd_out_if.source                       out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [awmd_pkg::PADDR_W-1:0]     paddr,
  input  logic [awmd_pkg::WORD_W-1:0]      pwdata,
  output logic [awmd_pkg::WORD_W-1:0]      prdata,
  output logic                             pready
);
  import awmd_pkg::*;

  logic [CFG_W-1:0] mask_channels_q;
  logic             cfg_wr;
  awmd_quad_t       quad;

  logic       st_valid [DIV_STAGE_N+1];
  logic       st_ready [DIV_STAGE_N+1];
  awmd_work_t st_work  [DIV_STAGE_N+1];
  logic [DIV_STAGE_N:0] st_valid_vec;

  // config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MASK_CH);
  assign prdata = (paddr[PADDR_W-1] == REG_MASK_CH) ? WORD_W'(mask_channels_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_channels_q <= MASK_CH_RESET;
    end else if (cfg_wr) begin
      mask_channels_q <= pwdata[CFG_W-1:0];
    end
  end

  assign quad.texel[0] = in_if.texel_top_left;
  assign quad.texel[1] = in_if.texel_top_right;
  assign quad.texel[2] = in_if.texel_bottom_left;
  assign quad.texel[3] = in_if.texel_bottom_right;
  assign quad.mask[0]  = in_if.mask_top_left;
  assign quad.mask[1]  = in_if.mask_top_right;
  assign quad.mask[2]  = in_if.mask_bottom_left;
  assign quad.mask[3]  = in_if.mask_bottom_right;

  awmd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_if.valid),
    .ready_o         (in_if.ready),
    .quad_i          (quad),
    .mask_channels_i (mask_channels_q),
    .valid_o         (st_valid[0]),
    .ready_i         (st_ready[0]),
    .work_o          (st_work[0])
  );

  for (genvar k = 0; k < DIV_STAGE_N; k++) begin : g_div
    awmd_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .work_i  (st_work[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .work_o  (st_work[k+1])
    );
  end

  for (genvar k = 0; k <= DIV_STAGE_N; k++) begin : g_vvec
    assign st_valid_vec[k] = st_valid[k];
  end

  assign st_ready[DIV_STAGE_N] = out_if.ready;
  assign out_if.valid = st_valid[DIV_STAGE_N];

  always_comb begin
    out_if.out_texel = {st_work[DIV_STAGE_N].alpha,
                        st_work[DIV_STAGE_N].quo[2],
                        st_work[DIV_STAGE_N].quo[1],
                        st_work[DIV_STAGE_N].quo[0]};
    for (int c = 0; c < MASK_N; c++) begin
      out_if.out_mask[BYTE_W*c +: BYTE_W] = st_work[DIV_STAGE_N].mask_en[c]
                                          ? st_work[DIV_STAGE_N].quo[COLOR_N+c]
                                          : '0;
    end
  end

  // a full, stalled pipe takes no new word
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&st_valid_vec) && !out_if.ready |-> !in_if.ready)
    else $error("input accepted into a full stalled pipe");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> mask_channels_q == $past(pwdata[CFG_W-1:0]))
    else $error("mask_channels write lost");

  a_one_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && mask_channels_q == CFG_W'(1) |-> out_if.out_mask[WORD_W-1:BYTE_W] == '0)
    else $error("inactive mask channel not zero");

  a_no_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && mask_channels_q == '0 |-> out_if.out_mask == '0)
    else $error("mask not zero with no active channel");

endmodule

// ===== bench/awmd_downsample_checker.sv =====
// ----------------------------------------------------------------------------
// awmd_downsample_checker
// Watches the quad and texel channels and the register port of the mip
// downsampler. Each accepted quad is turned into the expected downsampled
// word under the current mask_channels value; each accepted output word is
// compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module awmd_downsample_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  awmd_in_if                           quad_mon,
  awmd_out_if                          texel_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [awmd_pkg::PADDR_W-1:0] paddr,
  input  logic [awmd_pkg::WORD_W-1:0]  pwdata,
  output int                           mismatches,
  output int                           pending,
  output int                           words_checked,
  output int                           quads_seen,
  output int                           clear_quads
);
  import awmd_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] texel;
    logic [WORD_W-1:0] mask;
  } texel_word_t;

  logic [CFG_W-1:0] mask_channels_q;
  texel_word_t      expected_texels[$];
  awmd_quad_t       seen_quad;
  texel_word_t      want;
  int               fail_count;
  int               checked_count;
  int               quad_count;
  int               clear_count;

  function automatic texel_word_t downsample_quad(input awmd_quad_t quad,
                                                  input logic [CFG_W-1:0] n_mask);
    logic [ASUM_W-1:0] alpha_sum;
    logic [ASUM_W-1:0] plain_sum;
    logic [NUM_W-1:0]  weighted_sum;
    logic [NUM_W-1:0]  quo;
    texel_word_t       res;
    alpha_sum = '0;
    res       = '0;
    for (int q = 0; q < QUAD_N; q++) alpha_sum += quad.texel[q][31:24];
    res.texel[31:24] = 8'((alpha_sum + 2) / 4);
    for (int c = 0; c < COLOR_N; c++) begin
      weighted_sum = '0;
      plain_sum    = '0;
      for (int q = 0; q < QUAD_N; q++) begin
        weighted_sum += quad.texel[q][8*c +: 8] * quad.texel[q][31:24];
        plain_sum    += quad.texel[q][8*c +: 8];
      end
      if (alpha_sum != 0) begin
        quo = (weighted_sum + alpha_sum / 2) / alpha_sum;
      end else begin
        quo = (plain_sum + 2) / 4;
      end
      res.texel[8*c +: 8] = quo[7:0];
    end
    for (int c = 0; c < MASK_N; c++) begin
      if (c < n_mask) begin
        weighted_sum = '0;
        plain_sum    = '0;
        for (int q = 0; q < QUAD_N; q++) begin
          weighted_sum += quad.mask[q][8*c +: 8] * quad.texel[q][31:24];
          plain_sum    += quad.mask[q][8*c +: 8];
        end
        if (alpha_sum != 0) begin
          quo = weighted_sum / alpha_sum;
        end else begin
          quo = plain_sum / 4;
        end
        res.mask[8*c +: 8] = quo[7:0];
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic [WORD_W-1:0] want_v,
                               input logic [WORD_W-1:0] got_v);
    if (fail_count < 10) begin
      $display("mismatch on %s at %0t: expected %08h, got %08h", field, $time, want_v,
               got_v);
    end
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_channels_q = MASK_CH_RESET;
      expected_texels.delete();
      fail_count    = 0;
      checked_count = 0;
      quad_count    = 0;
      clear_count   = 0;
      mismatches    <= 0;
      pending       <= 0;
      words_checked <= 0;
      quads_seen    <= 0;
      clear_quads   <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_MASK_CH) begin
        mask_channels_q = pwdata[CFG_W-1:0];
      end
      if (texel_mon.valid && texel_mon.ready) begin
        if (expected_texels.size() == 0) begin
          note_mismatch("unexpected word, texel", '0, texel_mon.out_texel);
        end else begin
          want = expected_texels.pop_front();
          checked_count++;
          if (texel_mon.out_texel !== want.texel) begin
            note_mismatch("out_texel", want.texel, texel_mon.out_texel);
          end
          if (texel_mon.out_mask !== want.mask) begin
            note_mismatch("out_mask", want.mask, texel_mon.out_mask);
          end
        end
      end
      if (quad_mon.valid && quad_mon.ready) begin
        seen_quad.texel[0] = quad_mon.texel_top_left;
        seen_quad.texel[1] = quad_mon.texel_top_right;
        seen_quad.texel[2] = quad_mon.texel_bottom_left;
        seen_quad.texel[3] = quad_mon.texel_bottom_right;
        seen_quad.mask[0]  = quad_mon.mask_top_left;
        seen_quad.mask[1]  = quad_mon.mask_top_right;
        seen_quad.mask[2]  = quad_mon.mask_bottom_left;
        seen_quad.mask[3]  = quad_mon.mask_bottom_right;
        expected_texels = {expected_texels, downsample_quad(seen_quad, mask_channels_q)};
        quad_count++;
        if (seen_quad.texel[0][31:24] == 0 && seen_quad.texel[1][31:24] == 0 &&
            seen_quad.texel[2][31:24] == 0 && seen_quad.texel[3][31:24] == 0) begin
          clear_count++;
        end
      end
      mismatches    <= fail_count;
      pending       <= expected_texels.size();
      words_checked <= checked_count;
      quads_seen    <= quad_count;
      clear_quads   <= clear_count;
    end
  end

endmodule

// ===== bench/alpha_weighted_mip_downsample_tb.sv =====
// ----------------------------------------------------------------------------
// alpha_weighted_mip_downsample_tb
// Drives texel quads into the mip downsampler in bursts while the output
// side stalls in changing patterns. A directed set covers the arithmetic
// corners, then random quads run under a series of mask_channels settings,
// each after the first written over the register port once the pipeline is empty.
// ----------------------------------------------------------------------------
module alpha_weighted_mip_downsample_tb;
  import awmd_pkg::*;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum logic [1:0] {MIX_RANDOM, MIX_CLEAR, MIX_CORNER, MIX_SINGLE} quad_mix_e;

  localparam int SETTING_N         = 8;
  localparam int QUADS_PER_SETTING = 75;
  localparam int DRAIN_LIMIT       = 5000;
  localparam int SETTLE_CYCLES     = 10;
  localparam logic [CFG_W-1:0] SETTING_SEQ [SETTING_N] =
    '{MASK_CH_RESET, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [WORD_W-1:0]  pwdata;
  logic [WORD_W-1:0]  prdata;
  logic               pready;

  int mismatches;
  int pending;
  int words_checked;
  int quads_seen;
  int clear_quads;
  int burst_left;

  rx_mode_e   rx_mode  = RX_ALWAYS;
  logic [5:0] rx_cycle = '0;

  awmd_in_if  quad_if();
  awmd_out_if texel_if();

  alpha_weighted_mip_downsample dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (quad_if),
    .out_if  (texel_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  awmd_downsample_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .quad_mon      (quad_if),
    .texel_mon     (texel_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked),
    .quads_seen    (quads_seen),
    .clear_quads   (clear_quads)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("run timed out with %0d words outstanding", pending);
    $display("TEST FAILED");
    $finish;
  end

  // output side stall pattern, switched whenever rx_cycle wraps to zero
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 6'd1;
    if (rx_cycle == '0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: begin
        texel_if.ready <= 1'b1;
      end
      RX_COIN: begin
        texel_if.ready <= 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        texel_if.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        texel_if.ready <= (rx_cycle[1:0] != 2'd0);
      end
    endcase
  end

  task automatic push_quad(input logic [QUAD_N-1:0][WORD_W-1:0] tex,
                           input logic [QUAD_N-1:0][WORD_W-1:0] msk);
    int gap;
    quad_if.texel_top_left     <= tex[0];
    quad_if.texel_top_right    <= tex[1];
    quad_if.texel_bottom_left  <= tex[2];
    quad_if.texel_bottom_right <= tex[3];
    quad_if.mask_top_left      <= msk[0];
    quad_if.mask_top_right     <= msk[1];
    quad_if.mask_bottom_left   <= msk[2];
    quad_if.mask_bottom_right  <= msk[3];
    quad_if.valid              <= 1'b1;
    do @(posedge clk_i); while (!quad_if.ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        quad_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic push_random_quad();
    logic [QUAD_N-1:0][WORD_W-1:0] tex;
    logic [QUAD_N-1:0][WORD_W-1:0] msk;
    logic [7:0]                    corner_byte [4];
    quad_mix_e                     mix;
    int                            lit;
    int                            pick;
    corner_byte = '{8'h00, 8'h01, 8'hFE, 8'hFF};
    pick = $urandom_range(0, 19);
    mix  = (pick < 8) ? MIX_RANDOM : (pick < 12) ? MIX_CLEAR :
           (pick < 17) ? MIX_CORNER : MIX_SINGLE;
    lit  = $urandom_range(0, QUAD_N - 1);
    for (int q = 0; q < QUAD_N; q++) begin
      tex[q] = $urandom();
      msk[q] = $urandom();
      case (mix)
        MIX_CLEAR: begin
          tex[q][31:24] = 8'h00;
        end
        MIX_CORNER: begin
          tex[q][31:24] = corner_byte[$urandom_range(0, 3)];
          for (int b = 0; b < COLOR_N; b++) begin
            if ($urandom_range(0, 1)) tex[q][8*b +: 8] = corner_byte[$urandom_range(0, 3)];
          end
          for (int b = 0; b < MASK_N; b++) begin
            if ($urandom_range(0, 1)) msk[q][8*b +: 8] = corner_byte[$urandom_range(0, 3)];
          end
        end
        MIX_SINGLE: begin
          if (q != lit) tex[q][31:24] = 8'h00;
          else tex[q][31:24] = 8'($urandom_range(1, 255));
        end
        default: begin
        end
      endcase
    end
    push_quad(tex, msk);
  endtask

  // corners of the rounding and the zero-alpha fallback
  task automatic run_directed();
    push_quad('0, '0);
    push_quad('1, '1);
    push_quad({4{32'h00FF_FFFF}}, '1);
    push_quad({32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000},
              {32'h0300_0003, 32'h0300_0003, 32'h0300_0000, 32'h0000_0000});
    push_quad({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h01AB_CDEF},
              {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678});
    push_quad({32'h0100_0000, 32'h0100_0101, 32'h0000_0000, 32'h0000_0000},
              {32'h0000_0000, 32'h0101_0101, 32'h0000_0000, 32'h0000_0000});
    push_quad({32'hFF00_FF00, 32'hFFFF_00FF, 32'hFF12_3456, 32'hFF80_8080},
              {32'h0102_0304, 32'hFFEE_DDCC, 32'h8000_7F01, 32'h00FF_FF00});
    push_quad({32'h01FF_0000, 32'h0200_FF00, 32'h0300_00FF, 32'h04FF_FFFF},
              {32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_FF00, 32'h00FF_00FF});
    push_quad({32'hFF00_0000, 32'h01FF_FFFF, 32'h0000_0000, 32'h0000_0000},
              {32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    push_quad({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFEFF_FFFF}, '1);
    push_quad({32'h0200_7F80, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
              {32'h8040_2010, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    push_quad({32'h0001_0101, 32'h0001_0101, 32'h0001_0101, 32'h0000_0000},
              {32'h0303_0303, 32'h0000_0000, 32'h0101_0101, 32'h0000_0000});
    push_quad({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
              {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    quad_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic write_mask_channels(input logic [CFG_W-1:0] value);
    logic [WORD_W-1:0] data;
    data            = $urandom();
    data[CFG_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MASK_CH, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_ni                     <= 1'b0;
    psel                       <= 1'b0;
    penable                    <= 1'b0;
    pwrite                     <= 1'b0;
    paddr                      <= '0;
    pwdata                     <= '0;
    quad_if.valid              <= 1'b0;
    quad_if.texel_top_left     <= '0;
    quad_if.texel_top_right    <= '0;
    quad_if.texel_bottom_left  <= '0;
    quad_if.texel_bottom_right <= '0;
    quad_if.mask_top_left      <= '0;
    quad_if.mask_top_right     <= '0;
    quad_if.mask_bottom_left   <= '0;
    quad_if.mask_bottom_right  <= '0;
    burst_left = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < SETTING_N; p++) begin
      // first setting runs on the reset value
      if (p > 0) write_mask_channels(SETTING_SEQ[p]);
      if (p == 0) run_directed();
      repeat (QUADS_PER_SETTING) push_random_quad();
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d quads sent under %0d mask_channels settings, %0d of them fully transparent",
             quads_seen, SETTING_N, clear_quads);
    $display("%0d output words compared, %0d mismatches, %0d words missing",
             words_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
